/* hw/rtl/fat_cluster_chain_walker_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cluster chain walker
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAT_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT_CLUSTER_CHAIN_WALKER_MACROS_SVH

// same-cycle implication
`define FCCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fccw_pkg.sv */
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared constants, codes and controller/datapath interface types for the
// cluster chain walker.
// ----------------------------------------------------------------------------
package fccw_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // field widths
    localparam int REQ_W     = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 32;
    localparam int TSIZE_W   = 7;
    localparam int CLUSTER_W = 6;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    // first index covered by a free scan
    localparam int SCAN_FIRST = 2;

    // register reset values and indexes
    localparam logic [VALUE_W-1:0]   END_MARKER_RST = 32'h0FFF_FFFF;
    localparam logic [TSIZE_W-1:0]   TABLE_SIZE_RST = 7'd64;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_CHAIN = 2'd1,
        REQ_SCAN  = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        RS_CLUSTER   = 2'd0,
        RS_EMPTY     = 2'd1,
        RS_NONE_FREE = 2'd2,
        RS_BROKEN    = 2'd3
    } res_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAIN_FIRST,
        S_CHAIN_WALK,
        S_CHAIN_BROKEN,
        S_SCAN,
        S_SCAN_DONE
    } fsm_state_t;

    // table read address source
    typedef enum logic [1:0] {
        SRC_PORT,
        SRC_PTR,
        SRC_NEXT,
        SRC_SCAN0
    } rd_src_t;

    // cluster field source of an emitted word
    typedef enum logic [1:0] {
        CL_CUR,
        CL_PEND,
        CL_ZERO
    } cl_src_t;

    typedef struct packed {
        logic        mem_wr;
        logic        fetch;
        rd_src_t     rd_src;
        logic        cnt_clr;
        logic        found_clr;
        logic        pend_ld;
        logic        emit;
        cl_src_t     emit_cl;
        res_status_t emit_status;
        logic        emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic start_oob;
        logic is_zero;
        logic is_end;
        logic ptr_oob;
        logic visit_max;
        logic bound_small;
        logic scan_last;
        logic found;
    } dp_stat_t;

endpackage

/* hw/rtl/fccw_dp.sv */
// ----------------------------------------------------------------------------
// fccw_dp
// Datapath: allocation table memory with per-entry valid bits, config
// registers, walk/scan registers and the registered result word.
// ----------------------------------------------------------------------------
module fccw_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fccw_pkg::dp_cmd_t                 cmd,
    output fccw_pkg::dp_stat_t                stat,
    input  logic [fccw_pkg::INDEX_W-1:0]      entry_index,
    input  logic [fccw_pkg::VALUE_W-1:0]      entry_value,
    input  logic                              cfg_we,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [fccw_pkg::VALUE_W-1:0]      cfg_wdata,
    output logic                              result_valid,
    output logic [fccw_pkg::CLUSTER_W-1:0]    cluster,
    output logic [fccw_pkg::STATUS_W-1:0]     status,
    output logic                              last
);

    localparam int IDX_W   = fccw_pkg::IDX_W;
    localparam int TSIZE_W = fccw_pkg::TSIZE_W;
    localparam int VALUE_W = fccw_pkg::VALUE_W;
    localparam logic [fccw_pkg::INDEX_W:0] DEPTH_EXT =
        (fccw_pkg::INDEX_W + 1)'(fccw_pkg::TABLE_DEPTH);
    localparam logic [TSIZE_W-1:0] DEPTH_TS = TSIZE_W'(fccw_pkg::TABLE_DEPTH);

    // table storage
    logic [VALUE_W-1:0]               table_mem [fccw_pkg::TABLE_DEPTH];
    logic [fccw_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [VALUE_W-1:0]               rdq_reg;
    logic                             vldq_reg;

    // config
    logic [VALUE_W-1:0] end_marker_reg;
    logic [TSIZE_W-1:0] table_size_reg;

    // walk / scan state
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] pend_reg, pend_next;
    logic             found_reg, found_next;

    // result word
    logic                            result_valid_reg;
    logic [fccw_pkg::CLUSTER_W-1:0]  cluster_reg, cluster_next;
    logic [fccw_pkg::STATUS_W-1:0]   status_reg;
    logic                            last_reg;

    logic [VALUE_W-1:0] data;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [TSIZE_W-1:0] bound;

    assign wr_addr = entry_index[IDX_W-1:0];

    // entry never written reads as free
    assign data = vldq_reg ? rdq_reg : '0;

    // read address select
    always_comb
    begin
        case (cmd.rd_src)
            fccw_pkg::SRC_PORT:  rd_addr = entry_index[IDX_W-1:0];
            fccw_pkg::SRC_PTR:   rd_addr = data[IDX_W-1:0];
            fccw_pkg::SRC_NEXT:  rd_addr = cur_reg + IDX_W'(1);
            fccw_pkg::SRC_SCAN0: rd_addr = IDX_W'(fccw_pkg::SCAN_FIRST);
            default:             rd_addr = cur_reg;
        endcase
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            table_mem[wr_addr] <= entry_value;
        end
        if (cmd.fetch)
        begin
            rdq_reg <= table_mem[rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vldq_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mem_wr)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.fetch)
            begin
                vldq_reg <= valid_reg[rd_addr];
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= fccw_pkg::END_MARKER_RST;
            table_size_reg <= fccw_pkg::TABLE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == fccw_pkg::CFG_END_MARKER)
            begin
                end_marker_reg <= cfg_wdata;
            end
            else
            begin
                table_size_reg <= cfg_wdata[TSIZE_W-1:0];
            end
        end
    end

    // walk / scan next values
    always_comb
    begin
        cur_next = cmd.fetch ? rd_addr : cur_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.fetch && (cmd.rd_src == fccw_pkg::SRC_PTR))
        begin
            cnt_next = cnt_reg + IDX_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
        pend_next  = cmd.pend_ld ? cur_reg : pend_reg;
        found_next = cmd.found_clr ? 1'b0 : (cmd.pend_ld ? 1'b1 : found_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
    end

    // result word
    always_comb
    begin
        case (cmd.emit_cl)
            fccw_pkg::CL_CUR:  cluster_next = fccw_pkg::CLUSTER_W'(cur_reg);
            fccw_pkg::CL_PEND: cluster_next = fccw_pkg::CLUSTER_W'(pend_reg);
            default:           cluster_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            cluster_reg <= cluster_next;
            status_reg  <= cmd.emit_status;
            last_reg    <= cmd.emit_last;
        end
    end

    assign result_valid = result_valid_reg;
    assign cluster      = cluster_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    // status to the controller
    assign bound = (table_size_reg > DEPTH_TS) ? DEPTH_TS : table_size_reg;

    always_comb
    begin
        stat.start_oob   = {1'b0, entry_index} >= DEPTH_EXT;
        stat.is_zero     = data == '0;
        stat.is_end      = data == end_marker_reg;
        stat.ptr_oob     = data >= VALUE_W'(fccw_pkg::TABLE_DEPTH);
        stat.visit_max   = cnt_reg == IDX_W'(fccw_pkg::TABLE_DEPTH - 1);
        stat.bound_small = bound <= TSIZE_W'(fccw_pkg::SCAN_FIRST);
        stat.scan_last   = (TSIZE_W'(cur_reg) + TSIZE_W'(1)) >= bound;
        stat.found       = found_reg;
    end

endmodule

/* hw/rtl/fccw_ctrl.sv */
// ----------------------------------------------------------------------------
// fccw_ctrl
// Controller: takes requests, sequences chain walks and free scans one
// table read per cycle, and tells the datapath when to emit a word.
// ----------------------------------------------------------------------------
`include "fat_cluster_chain_walker_macros.svh"

module fccw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fccw_pkg::REQ_W-1:0]    req_type,
    output logic                          busy,
    input  fccw_pkg::dp_stat_t            stat,
    output fccw_pkg::dp_cmd_t             cmd
);

    fccw_pkg::fsm_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fccw_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != fccw_pkg::S_IDLE;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            fccw_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (fccw_pkg::req_t'(req_type))
                        fccw_pkg::REQ_WRITE:
                        begin
                            cmd.mem_wr = !stat.start_oob;
                        end
                        fccw_pkg::REQ_CHAIN:
                        begin
                            if (stat.start_oob)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_cl     = fccw_pkg::CL_ZERO;
                                cmd.emit_status = fccw_pkg::RS_BROKEN;
                                cmd.emit_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.fetch   = 1'b1;
                                cmd.rd_src  = fccw_pkg::SRC_PORT;
                                cmd.cnt_clr = 1'b1;
                                state_next  = fccw_pkg::S_CHAIN_FIRST;
                            end
                        end
                        fccw_pkg::REQ_SCAN:
                        begin
                            if (stat.bound_small)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_cl     = fccw_pkg::CL_ZERO;
                                cmd.emit_status = fccw_pkg::RS_NONE_FREE;
                                cmd.emit_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.fetch     = 1'b1;
                                cmd.rd_src    = fccw_pkg::SRC_SCAN0;
                                cmd.found_clr = 1'b1;
                                state_next    = fccw_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            // unused request code: taken and dropped
                        end
                    endcase
                end
            end

            // one cluster per cycle; empty start only tested on the first
            fccw_pkg::S_CHAIN_FIRST, fccw_pkg::S_CHAIN_WALK:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_cl = fccw_pkg::CL_CUR;
                if ((state_reg == fccw_pkg::S_CHAIN_FIRST) && stat.is_zero)
                begin
                    cmd.emit_status = fccw_pkg::RS_EMPTY;
                    cmd.emit_last   = 1'b1;
                    state_next      = fccw_pkg::S_IDLE;
                end
                else if (stat.is_end)
                begin
                    cmd.emit_status = fccw_pkg::RS_CLUSTER;
                    cmd.emit_last   = 1'b1;
                    state_next      = fccw_pkg::S_IDLE;
                end
                else if (stat.visit_max)
                begin
                    cmd.emit_cl     = fccw_pkg::CL_ZERO;
                    cmd.emit_status = fccw_pkg::RS_BROKEN;
                    cmd.emit_last   = 1'b1;
                    state_next      = fccw_pkg::S_IDLE;
                end
                else
                begin
                    cmd.emit_status = fccw_pkg::RS_CLUSTER;
                    if (stat.ptr_oob)
                    begin
                        state_next = fccw_pkg::S_CHAIN_BROKEN;
                    end
                    else
                    begin
                        cmd.fetch  = 1'b1;
                        cmd.rd_src = fccw_pkg::SRC_PTR;
                        state_next = fccw_pkg::S_CHAIN_WALK;
                    end
                end
            end

            fccw_pkg::S_CHAIN_BROKEN:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_cl     = fccw_pkg::CL_ZERO;
                cmd.emit_status = fccw_pkg::RS_BROKEN;
                cmd.emit_last   = 1'b1;
                state_next      = fccw_pkg::S_IDLE;
            end

            // free entries are held back one step so the final one gets last
            fccw_pkg::S_SCAN:
            begin
                if (stat.is_zero)
                begin
                    cmd.pend_ld = 1'b1;
                    if (stat.found)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_cl     = fccw_pkg::CL_PEND;
                        cmd.emit_status = fccw_pkg::RS_CLUSTER;
                    end
                end
                if (stat.scan_last)
                begin
                    state_next = fccw_pkg::S_SCAN_DONE;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    cmd.rd_src = fccw_pkg::SRC_NEXT;
                end
            end

            fccw_pkg::S_SCAN_DONE:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                if (stat.found)
                begin
                    cmd.emit_cl     = fccw_pkg::CL_PEND;
                    cmd.emit_status = fccw_pkg::RS_CLUSTER;
                end
                else
                begin
                    cmd.emit_cl     = fccw_pkg::CL_ZERO;
                    cmd.emit_status = fccw_pkg::RS_NONE_FREE;
                end
                state_next = fccw_pkg::S_IDLE;
            end

            default:
            begin
                state_next = fccw_pkg::S_IDLE;
            end
        endcase
    end

    // table is only written between requests
    `FCCW_ASSERT_IMP(a_wr_idle, cmd.mem_wr, state_reg == fccw_pkg::S_IDLE, "write while busy")
    // final word ends the request
    `FCCW_ASSERT_NXT(a_last_ends, cmd.emit && cmd.emit_last, state_reg == fccw_pkg::S_IDLE, "still busy after last word")
    // any other word keeps the request running
    `FCCW_ASSERT_NXT(a_mid_busy, cmd.emit && !cmd.emit_last, state_reg != fccw_pkg::S_IDLE, "request ended without last word")
    // a read is always followed by a state that consumes it
    `FCCW_ASSERT_NXT(a_fetch_used, cmd.fetch, state_reg == fccw_pkg::S_CHAIN_FIRST || state_reg == fccw_pkg::S_CHAIN_WALK || state_reg == fccw_pkg::S_SCAN, "table read not consumed")

endmodule

/* hw/rtl/fat_cluster_chain_walker.sv */
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker
// Allocation table of 32-bit entries with chain walk and free scan requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a request word (req_type, entry_index, entry_value) is
//   taken at a clock edge with start high and busy low. A write stores one
//   entry in that cycle and busy stays low. A chain or scan raises busy
//   until its last result word has been issued.
//   Result channel: result_valid is high for one cycle per word, with
//   cluster, status and last; the final word of a request has last set.
//   The receiver cannot stall: one word may come out every cycle.
//   Timing: one table read per cycle from the single read port. A chain
//   holds busy while it issues its words; the first comes from the read
//   taken with the request and the rest follow one per cycle. A free scan
//   reads the entries below bound B (table_size capped at the table depth);
//   each free cluster is held until the next one is found, so a word may
//   trail its read. The last word of a chain or scan is out in the same
//   cycle that busy goes low. A scan bound of 2 or less gives its single
//   word the cycle after the request, busy staying low.
//   Config: cfg_we, cfg_addr (0 end_marker, 1 table_size), cfg_wdata; write
//   only while busy is low and no result word is pending.
//   Reset: all valid bits clear at once, so the whole table reads as free
//   right after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module fat_cluster_chain_walker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fccw_pkg::REQ_W-1:0]        req_type,
    input  logic [fccw_pkg::INDEX_W-1:0]      entry_index,
    input  logic [fccw_pkg::VALUE_W-1:0]      entry_value,
    input  logic                              cfg_we,
    input  logic [fccw_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [fccw_pkg::VALUE_W-1:0]      cfg_wdata,
    output logic                              result_valid,
    output logic [fccw_pkg::CLUSTER_W-1:0]    cluster,
    output logic [fccw_pkg::STATUS_W-1:0]     status,
    output logic                              last
);

    fccw_pkg::dp_cmd_t  cmd;
    fccw_pkg::dp_stat_t stat;

    // request sequencer
    fccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and result datapath
    fccw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .cluster      (cluster),
        .status       (status),
        .last         (last)
    );

endmodule
